FILE: rtl/sbafd_pkg.sv
// ----------------------------------------------------------------------------
// sbafd_pkg: shared definitions for the subband analysis decimator
// Field widths, fixed-point constants and the types passed between modules.
// ----------------------------------------------------------------------------
package sbafd_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int TAP_W        = 16;
    localparam int COEF_W       = TAP_W + 1;
    localparam int OUT_W        = 24;
    localparam int NUM_TAP_REGS = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int DEF_TAPS     = 8;
    localparam int MAX_RESULTS  = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int ROUND_SHIFT  = 14;
    localparam int ROUND_BIAS   = 1 << (ROUND_SHIFT - 1);
    localparam int SAT_HI       = (2 ** (OUT_W - 1)) - 1;
    localparam int SAT_LO       = -(2 ** (OUT_W - 1));

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [TAP_W-1:0]     data;
    } t_cfg_wr;

endpackage

FILE: rtl/sbafd_queue.sv
// ----------------------------------------------------------------------------
// sbafd_queue: job queue between front and filter
// Small register FIFO; one push and one pop per cycle, head shown directly.
// ----------------------------------------------------------------------------
module sbafd_queue
    import sbafd_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W-1:0] r_wr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue pushed while full");

endmodule

FILE: rtl/sbafd_front.sv
// ----------------------------------------------------------------------------
// sbafd_front: line window and job issue
// Collects the line left-justified, issues one filter job per even output
// position and walks the pending positions at the end of a line.
// ----------------------------------------------------------------------------
module sbafd_front
    import sbafd_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  t_sample                       i_sample,
    input  logic                          i_line_end,
    input  logic                          i_q_full,
    output logic                          o_push,
    output logic [TAPS*SAMPLE_W:0]        o_job
);

    localparam int JOB_W       = TAPS * SAMPLE_W + 1;
    localparam int FILL_W      = $clog2(TAPS + 1);
    localparam int REM_W       = $clog2(MAX_RESULTS + 1);
    localparam int CNT_W       = (FILL_W > REM_W) ? FILL_W : REM_W;
    localparam logic TAPS_M1_ODD = 1'((TAPS - 1) % 2);

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    t_state            r_state;
    t_sample           r_win [TAPS];
    logic [FILL_W-1:0] r_fill;
    logic              r_par;
    logic [REM_W-1:0]  r_rem;

    t_sample           w_ins     [TAPS];
    t_sample           w_al      [TAPS];
    t_sample           w_al_sh2  [TAPS];
    t_sample           w_win_sh2 [TAPS];
    t_sample           w_job_win [TAPS];
    logic              w_job_last;
    logic              w_full;
    logic [FILL_W-1:0] w_fill_new;
    logic              w_q0_odd;
    logic [CNT_W-1:0]  w_pend;
    logic [CNT_W-1:0]  w_jobs;
    logic [CNT_W-1:0]  w_cap;
    logic              w_accept;

    assign o_in_stall = (r_state == ST_FLUSH) || i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_full = (r_fill == FILL_W'(TAPS));
        for (int w = 0; w < TAPS; w++) begin
            if (w_full) begin
                w_ins[w] = (w < TAPS - 1) ? r_win[(w + 1) % TAPS] : i_sample;
            end else begin
                w_ins[w] = (FILL_W'(w) == r_fill) ? i_sample : r_win[w];
            end
        end
        w_fill_new = w_full ? r_fill : r_fill + 1'b1;
        w_q0_odd   = w_full && (r_par ^ TAPS_M1_ODD);
        for (int w = 0; w < TAPS; w++) begin
            if (w_q0_odd) begin
                w_al[w] = (w < TAPS - 1) ? w_ins[(w + 1) % TAPS] : '0;
            end else begin
                w_al[w] = w_ins[w];
            end
        end
        for (int w = 0; w < TAPS; w++) begin
            w_al_sh2[w]  = (w < TAPS - 2) ? w_al[(w + 2) % TAPS] : '0;
            w_win_sh2[w] = (w < TAPS - 2) ? r_win[(w + 2) % TAPS] : '0;
        end
        w_pend = CNT_W'(w_fill_new) - CNT_W'(1) - CNT_W'(w_q0_odd);
        w_jobs = (w_pend + CNT_W'(1)) >> 1;
        w_cap  = (w_jobs > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : w_jobs;

        o_push     = 1'b0;
        w_job_last = 1'b0;
        w_job_win  = w_ins;
        unique case (r_state)
            ST_RUN: begin
                if (w_accept) begin
                    if (i_line_end) begin
                        o_push     = (w_cap != '0);
                        w_job_last = (w_cap == CNT_W'(1));
                        w_job_win  = w_al;
                    end else begin
                        o_push = (w_fill_new == FILL_W'(TAPS)) && !w_q0_odd;
                    end
                end
            end
            ST_FLUSH: begin
                o_push     = !i_q_full;
                w_job_last = (r_rem == REM_W'(1));
                w_job_win  = r_win;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase

        for (int w = 0; w < TAPS; w++) begin
            o_job[w*SAMPLE_W +: SAMPLE_W] = w_job_win[w];
        end
        o_job[JOB_W-1] = w_job_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_fill  <= '0;
            r_par   <= 1'b0;
            r_rem   <= '0;
            for (int w = 0; w < TAPS; w++) begin
                r_win[w] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_RUN: begin
                    if (w_accept) begin
                        if (i_line_end) begin
                            r_fill <= '0;
                            r_par  <= 1'b0;
                            if (w_cap > CNT_W'(1)) begin
                                r_state <= ST_FLUSH;
                                r_win   <= w_al_sh2;
                                r_rem   <= REM_W'(w_cap - CNT_W'(1));
                            end else begin
                                for (int w = 0; w < TAPS; w++) begin
                                    r_win[w] <= '0;
                                end
                            end
                        end else begin
                            r_win  <= w_ins;
                            r_fill <= w_fill_new;
                            r_par  <= ~r_par;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!i_q_full) begin
                        r_rem <= r_rem - 1'b1;
                        if (r_rem == REM_W'(1)) begin
                            r_state <= ST_RUN;
                            for (int w = 0; w < TAPS; w++) begin
                                r_win[w] <= '0;
                            end
                        end else begin
                            r_win <= w_win_sh2;
                        end
                    end
                end
                default: begin
                    r_state <= ST_RUN;
                end
            endcase
        end
    end

    a_flush_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_rem != '0))
        else $error("flush with no pending job");

    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_line_end) |=> ((r_fill == '0) && !r_par))
        else $error("line state not cleared after line end");

endmodule

FILE: rtl/sbafd_filter.sv
// ----------------------------------------------------------------------------
// sbafd_filter: dual-band FIR datapath
// Tap registers, one multiplier lane per tap and band, a registered adder
// tree, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module sbafd_filter
    import sbafd_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg_wr                 i_cfg,
    input  logic                    i_job_valid,
    input  logic [TAPS*SAMPLE_W:0]  i_job,
    output logic                    o_job_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_low_band,
    output logic signed [OUT_W-1:0] o_high_band,
    output logic                    o_last_out
);

    localparam int JOB_W  = TAPS * SAMPLE_W + 1;
    localparam int LVL    = $clog2(TAPS);
    localparam int TREE_N = 1 << LVL;
    localparam int NODES  = 2 * TREE_N - 1;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + LVL;
    localparam int RND_W  = ACC_W - ROUND_SHIFT;
    localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(ROUND_BIAS);
    localparam logic signed [RND_W-1:0] SAT_HI_R = RND_W'(SAT_HI);
    localparam logic signed [RND_W-1:0] SAT_LO_R = RND_W'(SAT_LO);

    logic signed [COEF_W-1:0] r_clo [TAPS];
    logic signed [COEF_W-1:0] r_chi [TAPS];
    logic signed [ACC_W-1:0]  r_lo  [NODES];
    logic signed [ACC_W-1:0]  r_hi  [NODES];
    logic                     r_vld [LVL+1];
    logic                     r_lst [LVL+1];
    logic signed [RND_W-1:0]  r_rnd_lo;
    logic signed [RND_W-1:0]  r_rnd_hi;
    logic                     r_rnd_vld;
    logic                     r_rnd_lst;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_lo;
    logic signed [OUT_W-1:0]  r_out_hi;
    logic                     r_out_lst;

    t_sample                  w_x    [TAPS];
    logic signed [PROD_W-1:0] w_plo  [TREE_N];
    logic signed [PROD_W-1:0] w_phi  [TREE_N];
    logic signed [COEF_W-1:0] w_tap;
    logic signed [ACC_W-1:0]  w_sum_lo;
    logic signed [ACC_W-1:0]  w_sum_hi;
    logic signed [OUT_W-1:0]  w_sat_lo;
    logic signed [OUT_W-1:0]  w_sat_hi;
    logic                     w_en;

    assign w_en        = !r_out_valid || !i_out_stall;
    assign o_job_pop   = w_en && i_job_valid;
    assign o_out_valid = r_out_valid;
    assign o_low_band  = r_out_lo;
    assign o_high_band = r_out_hi;
    assign o_last_out  = r_out_lst;
    assign w_tap       = {i_cfg.data[TAP_W-1], i_cfg.data};

    for (genvar w = 0; w < TREE_N; w++) begin : g_lane
        if (w < TAPS) begin : g_mul
            assign w_x[w]   = i_job[w*SAMPLE_W +: SAMPLE_W];
            assign w_plo[w] = w_x[w] * r_clo[w];
            assign w_phi[w] = w_x[w] * r_chi[w];
        end else begin : g_pad
            assign w_plo[w] = '0;
            assign w_phi[w] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < TAPS; w++) begin
                r_clo[w] <= '0;
                r_chi[w] <= '0;
            end
        end else if (i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_TAP_REGS))) begin
            for (int w = 0; w < TAPS; w++) begin
                if (i_cfg.index == CFG_IDX_W'(TAPS - 1 - w)) begin
                    r_clo[w] <= w_tap;
                end
                if (i_cfg.index == CFG_IDX_W'(w)) begin
                    r_chi[w] <= (w % 2 == 1) ? w_tap : -w_tap;
                end
            end
        end
    end

    always_comb begin
        w_sum_lo = r_lo[0] + ACC_BIAS;
        w_sum_hi = r_hi[0] + ACC_BIAS;
        if (r_rnd_lo > SAT_HI_R) begin
            w_sat_lo = OUT_W'(SAT_HI_R);
        end else if (r_rnd_lo < SAT_LO_R) begin
            w_sat_lo = OUT_W'(SAT_LO_R);
        end else begin
            w_sat_lo = r_rnd_lo[OUT_W-1:0];
        end
        if (r_rnd_hi > SAT_HI_R) begin
            w_sat_hi = OUT_W'(SAT_HI_R);
        end else if (r_rnd_hi < SAT_LO_R) begin
            w_sat_hi = OUT_W'(SAT_LO_R);
        end else begin
            w_sat_hi = r_rnd_hi[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int w = 0; w < TREE_N; w++) begin
                r_lo[TREE_N-1+w] <= {{(ACC_W-PROD_W){w_plo[w][PROD_W-1]}}, w_plo[w]};
                r_hi[TREE_N-1+w] <= {{(ACC_W-PROD_W){w_phi[w][PROD_W-1]}}, w_phi[w]};
            end
            for (int i = 0; i < TREE_N - 1; i++) begin
                r_lo[i] <= r_lo[2*i+1] + r_lo[2*i+2];
                r_hi[i] <= r_hi[2*i+1] + r_hi[2*i+2];
            end
            r_lst[0] <= i_job[JOB_W-1];
            for (int l = 1; l <= LVL; l++) begin
                r_lst[l] <= r_lst[l-1];
            end
            r_rnd_lo  <= w_sum_lo[ACC_W-1:ROUND_SHIFT];
            r_rnd_hi  <= w_sum_hi[ACC_W-1:ROUND_SHIFT];
            r_rnd_lst <= r_lst[LVL];
            r_out_lo  <= w_sat_lo;
            r_out_hi  <= w_sat_hi;
            r_out_lst <= r_rnd_lst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l <= LVL; l++) begin
                r_vld[l] <= 1'b0;
            end
            r_rnd_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_job_valid;
            for (int l = 1; l <= LVL; l++) begin
                r_vld[l] <= r_vld[l-1];
            end
            r_rnd_vld   <= r_vld[LVL];
            r_out_valid <= r_rnd_vld;
        end
    end

    a_out_from_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rnd_vld))
        else $error("output beat without a rounded result");

endmodule

FILE: rtl/subband_analysis_fir_decimator_core.sv
// ----------------------------------------------------------------------------
// subband_analysis_fir_decimator_core: two-band line analysis, decimate by 2
// Low-pass (reversed taps) and high-pass (even taps negated) FIR over a line,
// one result per even position, rounded and saturated to 24 bits.
// ----------------------------------------------------------------------------
// Line samples enter one per cycle while unstalled; each even output position
// yields a beat with both bands. A line end with k pending results (k at most
// 4) holds the input stall while the front sequencer issues the remaining
// filter jobs, one per cycle while the two-entry job queue has room, into the
// single filter pipeline. A job passes the product, adder tree, rounding and
// output registers. Taps are to be written through the config port (always
// ready, index 8 and above ignored) only while the block is idle; unchecked.
module subband_analysis_fir_decimator_core
    import sbafd_pkg::*;
#(
    parameter int TAPS   = DEF_TAPS,
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                    i_line_end,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [OUT_W-1:0] o_low_band,
    output logic signed [OUT_W-1:0] o_high_band,
    output logic                    o_last_out,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [TAP_W-1:0]        i_cfg_data
);

    localparam int JOB_W = TAPS * SAMPLE_W + 1;

    logic             w_push;
    logic [JOB_W-1:0] w_job_in;
    logic             w_q_full;
    logic             w_q_valid;
    logic [JOB_W-1:0] w_job_out;
    logic             w_pop;
    t_cfg_wr          w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    sbafd_front #(
        .TAPS (TAPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_line_end (i_line_end),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    sbafd_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_job_out)
    );

    sbafd_filter #(
        .TAPS (TAPS)
    ) u_filter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (w_q_valid),
        .i_job       (w_job_out),
        .o_job_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_low_band  (o_low_band),
        .o_high_band (o_high_band),
        .o_last_out  (o_last_out)
    );

endmodule
